/* rtl/stb_pkg.sv */
// shared constants and mode codes for the software timer bank
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed field widths of the request and expiry beats
    localparam int IDX_FIELD_W     = 3;
    localparam int RELOAD_FIELD_W  = 16;
    localparam int MODE_W          = 2;

    // at most this many expiry beats per tick
    localparam int RESULT_SLOTS    = 8;
    localparam int RPT_W           = 4;

    localparam logic REQ_TICK      = 1'b0;
    localparam logic REQ_WRITE     = 1'b1;

    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

endpackage

`default_nettype wire

/* rtl/stb_if.sv */
// request and expiry channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface stb_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic [stb_pkg::IDX_FIELD_W-1:0]      timer_index;
    logic [stb_pkg::RELOAD_FIELD_W-1:0]   reload_value;
    logic                                 auto_restart;
    logic [stb_pkg::MODE_W-1:0]           new_mode;

    modport source (
        output valid, req_type, timer_index, reload_value, auto_restart, new_mode,
        input  ready
    );
    modport sink (
        input  valid, req_type, timer_index, reload_value, auto_restart, new_mode,
        output ready
    );
endinterface

interface stb_exp_if;
    logic                                 valid;
    logic                                 ready;
    logic [stb_pkg::IDX_FIELD_W-1:0]      expired_timer;
    logic                                 last_expiry;

    modport source (
        output valid, expired_timer, last_expiry,
        input  ready
    );
    modport sink (
        input  valid, expired_timer, last_expiry,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/software_timer_bank_core.sv */
// top level: tick / write sequencer over the timer ram, with expiry output register
// write beat: busy after acceptance (read, then read-modify-write), then ready
// tick beat: per timer a ram read and an update, then a closing step;
//   a stalled expiry beat holds the walk and adds its wait
// the single ram read port and the one shared update unit make the walk go one timer at a time
// reset: rst_n is asynchronous, active low; control, output valid and entry valid
//   bits clear at once, so every timer reads as stopped with zero count and reload
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank_core #(
    parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_BITS = stb_pkg::COUNT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stb_req_if.sink    req,
    stb_exp_if.source  expiry
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IXW_W = IDX_W + stb_pkg::IDX_FIELD_W;
    localparam int RLW_W = COUNT_BITS + stb_pkg::RELOAD_FIELD_W;
    // entry layout: {mode, restart, reload, count}
    localparam int ENT_W = stb_pkg::MODE_W + 1 + 2 * COUNT_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TRD   = 3'd1;
    localparam logic [2:0] S_TEVAL = 3'd2;
    localparam logic [2:0] S_TDONE = 3'd3;
    localparam logic [2:0] S_WRD   = 3'd4;
    localparam logic [2:0] S_WMOD  = 3'd5;

    // control registers
    logic [2:0]                         state_reg, state_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [stb_pkg::RPT_W-1:0]          rpt_reg, rpt_next;
    logic                               pend_vld_reg, pend_vld_next;
    logic [stb_pkg::IDX_FIELD_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                               out_vld_reg, out_vld_next;
    logic [NUM_TIMERS-1:0]              vld_reg, vld_next;

    // payload registers
    logic [stb_pkg::IDX_FIELD_W-1:0]    out_idx_reg, out_idx_next;
    logic                               out_last_reg, out_last_next;
    logic [COUNT_BITS-1:0]              wr_reload_reg, wr_reload_next;
    logic                               wr_restart_reg, wr_restart_next;
    logic [stb_pkg::MODE_W-1:0]         wr_mode_reg, wr_mode_next;

    // ram side
    logic                               ram_we;
    logic [ENT_W-1:0]                   ram_wdata;
    logic [ENT_W-1:0]                   ram_rdata;
    logic [ENT_W-1:0]                   entry;

    // update unit
    logic [stb_pkg::MODE_W-1:0]         ent_mode, upd_mode;
    logic [COUNT_BITS-1:0]              ent_count, ent_reload, upd_count;
    logic                               ent_restart, upd_expire;

    // helpers
    logic                               req_acc;
    logic                               out_free;
    logic                               idx_ok;
    logic [IXW_W-1:0]                   req_idx_wide;
    logic [IXW_W-1:0]                   cur_idx_wide;
    logic [RLW_W-1:0]                   req_reload_wide;
    logic                               last_timer;
    logic                               report;
    logic                               need_push;

    assign req.ready       = (state_reg == S_IDLE);
    assign req_acc         = req.valid && req.ready;

    assign expiry.valid         = out_vld_reg;
    assign expiry.expired_timer = out_idx_reg;
    assign expiry.last_expiry   = out_last_reg;

    // output register can take a beat when empty or draining this cycle
    assign out_free        = !out_vld_reg || expiry.ready;

    assign req_idx_wide    = IXW_W'(req.timer_index);
    assign cur_idx_wide    = IXW_W'(idx_reg);
    assign req_reload_wide = RLW_W'(req.reload_value);
    // writes to timers beyond the bank are dropped
    assign idx_ok          = (int'(req.timer_index) < NUM_TIMERS);
    assign last_timer      = (idx_reg == IDX_W'(NUM_TIMERS - 1));

    // an entry never written reads as the reset value (all zero, mode stop)
    assign entry       = vld_reg[idx_reg] ? ram_rdata : '0;
    assign ent_count   = entry[COUNT_BITS-1:0];
    assign ent_reload  = entry[2*COUNT_BITS-1:COUNT_BITS];
    assign ent_restart = entry[2*COUNT_BITS];
    assign ent_mode    = entry[ENT_W-1:2*COUNT_BITS+1];

    stb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    stb_upd #(
        .COUNT_BITS (COUNT_BITS)
    ) u_upd (
        .mode     (ent_mode),
        .count    (ent_count),
        .reload   (ent_reload),
        .restart  (ent_restart),
        .mode_nx  (upd_mode),
        .count_nx (upd_count),
        .expire   (upd_expire)
    );

    // expiry handling: the newest reported expiry waits in a pending slot so the
    // final one of the tick can be flagged once the walk is over
    assign report    = upd_expire && (rpt_reg < stb_pkg::RPT_W'(stb_pkg::RESULT_SLOTS));
    assign need_push = report && pend_vld_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rpt_next        = rpt_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        out_vld_next    = out_vld_reg && !expiry.ready;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        vld_next        = vld_reg;
        wr_reload_next  = wr_reload_reg;
        wr_restart_next = wr_restart_reg;
        wr_mode_next    = wr_mode_reg;
        ram_we          = 1'b0;
        ram_wdata       = {upd_mode, ent_restart, ent_reload, upd_count};

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    if (req.req_type == stb_pkg::REQ_TICK)
                    begin
                        idx_next      = '0;
                        rpt_next      = '0;
                        pend_vld_next = 1'b0;
                        state_next    = S_TRD;
                    end
                    else if (idx_ok)
                    begin
                        idx_next        = req_idx_wide[IDX_W-1:0];
                        wr_reload_next  = req_reload_wide[COUNT_BITS-1:0];
                        wr_restart_next = req.auto_restart;
                        wr_mode_next    = req.new_mode;
                        state_next      = S_WRD;
                    end
                end
            end
            S_TRD:
            begin
                state_next = S_TEVAL;
            end
            S_TEVAL:
            begin
                // hold the timer while an earlier expiry cannot leave
                if (!need_push || out_free)
                begin
                    ram_we            = 1'b1;
                    vld_next[idx_reg] = 1'b1;
                    if (need_push)
                    begin
                        out_vld_next  = 1'b1;
                        out_idx_next  = pend_idx_reg;
                        out_last_next = 1'b0;
                    end
                    if (report)
                    begin
                        pend_vld_next = 1'b1;
                        pend_idx_next = cur_idx_wide[stb_pkg::IDX_FIELD_W-1:0];
                        rpt_next      = rpt_reg + stb_pkg::RPT_W'(1);
                    end
                    if (last_timer)
                    begin
                        state_next = S_TDONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_TRD;
                    end
                end
            end
            S_TDONE:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_idx_next  = pend_idx_reg;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            S_WRD:
            begin
                state_next = S_WMOD;
            end
            S_WMOD:
            begin
                // settings replaced, remaining count kept
                ram_we            = 1'b1;
                ram_wdata         = {wr_mode_reg, wr_restart_reg, wr_reload_reg, ent_count};
                vld_next[idx_reg] = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            rpt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            out_vld_reg  <= 1'b0;
            vld_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            rpt_reg      <= rpt_next;
            pend_vld_reg <= pend_vld_next;
            pend_idx_reg <= pend_idx_next;
            out_vld_reg  <= out_vld_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
        wr_reload_reg  <= wr_reload_next;
        wr_restart_reg <= wr_restart_next;
        wr_mode_reg    <= wr_mode_next;
    end

endmodule

`default_nettype wire

/* rtl/stb_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/stb_upd.sv */
// per-timer update unit, shared by all timers during a tick walk
`timescale 1ns / 1ps
`default_nettype none

module stb_upd #(
    parameter int COUNT_BITS = stb_pkg::COUNT_BITS_DEF
) (
    input  wire logic [stb_pkg::MODE_W-1:0] mode,
    input  wire logic [COUNT_BITS-1:0]      count,
    input  wire logic [COUNT_BITS-1:0]      reload,
    input  wire logic                       restart,
    output logic      [stb_pkg::MODE_W-1:0] mode_nx,
    output logic      [COUNT_BITS-1:0]      count_nx,
    output logic                            expire
);

    always_comb
    begin
        mode_nx  = mode;
        count_nx = count;
        expire   = 1'b0;
        case (mode)
            stb_pkg::MODE_STOP:
            begin
                mode_nx = stb_pkg::MODE_STOP;
            end
            stb_pkg::MODE_RUN:
            begin
                if (count == '0)
                begin
                    expire = 1'b1;
                    if (restart)
                    begin
                        count_nx = reload;
                    end
                    else
                    begin
                        mode_nx = stb_pkg::MODE_STOP;
                    end
                end
                else
                begin
                    count_nx = count - COUNT_BITS'(1);
                end
            end
            stb_pkg::MODE_START:
            begin
                count_nx = reload;
                mode_nx  = stb_pkg::MODE_RUN;
            end
            default:
            begin
                // reset mode steps to start
                mode_nx = stb_pkg::MODE_START;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/stb_chk.sv */
// port-level checker for the timer bank, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module stb_chk (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                req_valid,
    input wire logic                                req_ready,
    input wire logic                                req_type,
    input wire logic                                exp_valid,
    input wire logic                                exp_ready,
    input wire logic [stb_pkg::IDX_FIELD_W-1:0]     exp_timer,
    input wire logic                                exp_last
);

    // a stalled expiry beat holds
    a_exp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid && !exp_ready |=> exp_valid && $stable(exp_timer) && $stable(exp_last))
        else $error("expiry beat changed while stalled");

    // a tick keeps the bank busy in the cycle after it is accepted
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == stb_pkg::REQ_TICK) |=> !req_ready)
        else $error("bank ready right after a tick");

    // a non-final expiry means the tick walk is still going
    a_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        exp_valid && !exp_last |-> !req_ready)
        else $error("bank idle with a non-final expiry pending");

    // a settings write produces no expiry beat
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == stb_pkg::REQ_WRITE) |=> !$rose(exp_valid))
        else $error("expiry beat started by a write");

endmodule

bind software_timer_bank_core stb_chk u_stb_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .exp_valid (expiry.valid),
    .exp_ready (expiry.ready),
    .exp_timer (expiry.expired_timer),
    .exp_last  (expiry.last_expiry)
);

`default_nettype wire

/* dv/software_timer_bank_core_tb.sv */
// self-checking testbench for the software timer bank core
`timescale 1ns / 1ps

module software_timer_bank_core_tb;

    localparam int TIMERS     = stb_pkg::NUM_TIMERS_DEF;
    localparam int CNT_W      = stb_pkg::COUNT_BITS_DEF;
    localparam int TICK_CYC   = 2 * TIMERS + 1;
    localparam int MAX_ERR_PR = 10;
    localparam int SLOTS      = stb_pkg::RESULT_SLOTS;

    // one request beat as the sender sees it
    typedef struct packed {
        logic                               req_type;
        logic [stb_pkg::IDX_FIELD_W-1:0]    timer_index;
        logic [stb_pkg::RELOAD_FIELD_W-1:0] reload_value;
        logic                               auto_restart;
        logic [stb_pkg::MODE_W-1:0]         new_mode;
    } timer_req_t;

    localparam int REQ_W = $bits(timer_req_t);

    // one expiry beat
    typedef struct packed {
        logic [stb_pkg::IDX_FIELD_W-1:0] expired_timer;
        logic                            last_expiry;
    } expiry_t;

    logic clk;
    logic rst_n;

    stb_req_if req_ch ();
    stb_exp_if exp_ch ();

    software_timer_bank_core #(
        .NUM_TIMERS (TIMERS),
        .COUNT_BITS (CNT_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .expiry (exp_ch)
    );

    // shadow copy of the timer bank
    logic [stb_pkg::MODE_W-1:0] bank_mode    [TIMERS];
    logic [CNT_W-1:0]           bank_count   [TIMERS];
    logic [CNT_W-1:0]           bank_reload  [TIMERS];
    logic                       bank_restart [TIMERS];

    // expiry beats still owed by the block, oldest first
    expiry_t pending_expiries[$];

    int error_count    = 0;
    int mismatch_count = 0;

    // handshake knobs set by the tests
    bit no_gaps      = 1'b0;   // when set neither side idles
    int stall_cycles = 0;      // long ready hold requested by a test

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous watchdog, far beyond the slowest legal run
    initial
    begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: applies one accepted request beat to the shadow bank and
    // queues the expiry beats a tick produces
    // ------------------------------------------------------------------
    task automatic advance_timer_bank(input timer_req_t b);
        int      t;
        int      hits;
        int      hit_idx [SLOTS];
        expiry_t e;
        hits = 0;
        if (b.req_type == stb_pkg::REQ_WRITE)
        begin
            // write beat: count untouched, no expiry
            if (int'(b.timer_index) < TIMERS)
            begin
                bank_reload[b.timer_index]  = b.reload_value[CNT_W-1:0];
                bank_restart[b.timer_index] = b.auto_restart;
                bank_mode[b.timer_index]    = b.new_mode;
            end
            return;
        end
        // tick beat: walk timers in index order
        for (t = 0; t < TIMERS; t++)
        begin
            case (bank_mode[t])
                stb_pkg::MODE_STOP:
                begin
                end
                stb_pkg::MODE_RUN:
                begin
                    if (bank_count[t] == '0)
                    begin
                        if (bank_restart[t])
                            bank_count[t] = bank_reload[t];
                        else
                            bank_mode[t] = stb_pkg::MODE_STOP;
                        if (hits < SLOTS)
                        begin
                            hit_idx[hits] = t;
                            hits++;
                        end
                    end
                    else
                        bank_count[t] = bank_count[t] - 1'b1;
                end
                stb_pkg::MODE_START:
                begin
                    bank_count[t] = bank_reload[t];
                    bank_mode[t]  = stb_pkg::MODE_RUN;
                end
                default:
                    bank_mode[t] = stb_pkg::MODE_START;
            endcase
        end
        for (t = 0; t < hits; t++)
        begin
            e.expired_timer = hit_idx[t][stb_pkg::IDX_FIELD_W-1:0];
            e.last_expiry   = (t == hits - 1);
            pending_expiries.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // drive one request beat and wait until it is taken
    task automatic send_request(input timer_req_t b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= b.req_type;
        req_ch.timer_index  <= b.timer_index;
        req_ch.reload_value <= b.reload_value;
        req_ch.auto_restart <= b.auto_restart;
        req_ch.new_mode     <= b.new_mode;
        do
            @(posedge clk);
        while (!req_ch.ready);
        advance_timer_bank(b);
    endtask

    // tick with junk in every ignored field
    task automatic send_tick();
        timer_req_t b;
        b              = timer_req_t'(REQ_W'($urandom));
        b.req_type     = stb_pkg::REQ_TICK;
        send_request(b);
    endtask

    task automatic send_write(input int idx,
                              input logic [stb_pkg::RELOAD_FIELD_W-1:0] reload,
                              input logic restart,
                              input logic [stb_pkg::MODE_W-1:0] mode);
        timer_req_t b;
        b.req_type     = stb_pkg::REQ_WRITE;
        b.timer_index  = idx[stb_pkg::IDX_FIELD_W-1:0];
        b.reload_value = reload;
        b.auto_restart = restart;
        b.new_mode     = mode;
        send_request(b);
    endtask

    // sender pauses until the block owes nothing more
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (pending_expiries.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver side: random ready gaps per beat, plus long holds on demand
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        exp_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            hold         = stall_cycles + (no_gaps ? 0 : $urandom_range(0, 5));
            stall_cycles = 0;
            if (hold > 0)
            begin
                exp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            exp_ch.ready <= 1'b1;
            // stay ready until a beat moves or a long hold is requested
            do
                @(posedge clk);
            while (!(exp_ch.valid && exp_ch.ready) && stall_cycles == 0);
        end
    end

    // expiry checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        expiry_t want;
        if (rst_n && exp_ch.valid && exp_ch.ready)
        begin
            if (pending_expiries.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_ERR_PR)
                    $display("%0t: expected no beat, got timer=%0d last=%0b",
                             $realtime, exp_ch.expired_timer, exp_ch.last_expiry);
            end
            else
            begin
                want = pending_expiries.pop_front();
                if (exp_ch.expired_timer !== want.expired_timer ||
                    exp_ch.last_expiry !== want.last_expiry)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_ERR_PR)
                        $display({"%0t: expiry mismatch exp timer=%0d last=%0b",
                                  " got timer=%0d last=%0b"},
                                 $realtime, want.expired_timer, want.last_expiry,
                                 exp_ch.expired_timer, exp_ch.last_expiry);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, run with zero count, tick with no expiry
    task automatic test_edge_values();
        send_write(0, 16'hFFFF, 1'b1, stb_pkg::MODE_STOP);
        send_write(7, 16'h0000, 1'b0, stb_pkg::MODE_RUN);   // zero count straight to run
        send_tick();                               // timer 7 expires and stops
        send_tick();                               // nothing running, no beat
    endtask

    // each mode, countdown, auto restart, write to a running timer
    task automatic test_mode_walk();
        send_write(1, 16'd2, 1'b0, stb_pkg::MODE_START);
        send_write(2, 16'd1, 1'b1, stb_pkg::MODE_RESET);
        send_write(3, 16'hFFFF, 1'b0, stb_pkg::MODE_START);
        send_tick();
        // count of timer 1 must survive this write
        send_write(1, 16'd9, 1'b1, stb_pkg::MODE_RUN);
        repeat (6) send_tick();
        send_write(1, 16'd0, 1'b0, stb_pkg::MODE_STOP);
        send_write(2, 16'd0, 1'b0, stb_pkg::MODE_STOP);
        send_write(3, 16'd0, 1'b0, stb_pkg::MODE_STOP);
        wait_for_drain();
    endtask

    // every timer expires on each tick after the first, with a long hold on the output
    task automatic test_full_bank_backpressure();
        int t;
        for (t = 0; t < TIMERS; t++)
            send_write(t, 16'd0, 1'b1, stb_pkg::MODE_START);
        send_tick();                    // all load zero and enter run
        stall_cycles = 200;
        repeat (4) send_tick();         // 32 beats, the tick walks stall behind the hold
        wait_for_drain();
        for (t = 0; t < TIMERS; t++)
            send_write(t, 16'($urandom), 1'($urandom), stb_pkg::MODE_STOP);
    endtask

    // mostly short reloads so expiries keep coming, some wide values
    task automatic test_random_traffic();
        int         i;
        int         pick;
        timer_req_t b;
        for (i = 0; i < 145; i++)
        begin
            no_gaps = (i >= 70 && i < 100);
            if (i % 45 == 44)
                wait_for_drain();
            b    = timer_req_t'(REQ_W'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 45)
                b.req_type = stb_pkg::REQ_TICK;
            else
            begin
                b.req_type = stb_pkg::REQ_WRITE;
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    b.new_mode = stb_pkg::MODE_START;
                else if (pick < 55)
                    b.new_mode = stb_pkg::MODE_RESET;
                else if (pick < 75)
                    b.new_mode = stb_pkg::MODE_RUN;
                else
                    b.new_mode = stb_pkg::MODE_STOP;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    b.reload_value = 16'($urandom_range(0, 6));
                else if (pick < 92)
                    b.reload_value = 16'($urandom_range(0, 65535));
                else if (pick < 96)
                    b.reload_value = 16'h0000;
                else
                    b.reload_value = 16'hFFFF;
            end
            send_request(b);
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int t;
        for (t = 0; t < TIMERS; t++)
        begin
            bank_mode[t]    = stb_pkg::MODE_STOP;
            bank_count[t]   = '0;
            bank_reload[t]  = '0;
            bank_restart[t] = 1'b0;
        end
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= stb_pkg::REQ_TICK;
        req_ch.timer_index  <= '0;
        req_ch.reload_value <= '0;
        req_ch.auto_restart <= 1'b0;
        req_ch.new_mode     <= stb_pkg::MODE_STOP;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_mode_walk();
        test_full_bank_backpressure();
        test_random_traffic();

        // drain, then allow one full tick walk for stray beats
        req_ch.valid <= 1'b0;
        while (pending_expiries.size() != 0)
            @(posedge clk);
        repeat (TICK_CYC + 8) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
